// ----- sv/scst_pkg.sv -----
package scst_pkg;

   // default number of entries in the shadow stack
   localparam int STACK_DEPTH_DEFAULT = 64;

   // event kinds
   localparam logic MODE_CALL   = 1'b0;
   localparam logic MODE_RETURN = 1'b1;

   // result status codes
   localparam logic [2:0] ST_PUSHED    = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_MATCHED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_BAD_SP    = 3'd4;

   // one input item
   typedef struct packed {
      logic        mode;
      logic [31:0] stack_pointer;
      logic [31:0] slot_value;
      logic [31:0] instr_pointer;
   } req_type;

   // one result item
   typedef struct packed {
      logic [2:0] status;
      logic [6:0] removed_count;
      logic [6:0] new_depth;
   } rsp_type;

   // one stack entry as held in memory
   typedef struct packed {
      logic [31:0] saved_pointer;
      logic [31:0] saved_slot;
   } entry_type;

endpackage

// ----- sv/scst_stack_ram.sv -----
module scst_stack_ram #(
   parameter int STACK_DEPTH = scst_pkg::STACK_DEPTH_DEFAULT,
   parameter int AW = $clog2(STACK_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  scst_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output scst_pkg::entry_type rd_data
);
   import scst_pkg::*;

   entry_type mem [STACK_DEPTH];
   entry_type rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/shadow_call_stack_tracker.sv -----
// Shadow call stack tracker.
// Input items arrive on req_valid/req_ready with a req_data payload (event
// kind, stack pointer, slot value, instruction pointer). One result item per
// input leaves on rsp_valid/rsp_ready with status, removed count and depth.
// csr_wr_en/csr_wr_data set the match-on-slot mode; write it only when idle.
// The stack lives in a single-port-write, registered-read entry memory. An
// event walks entries from the top, one memory read per cycle; no entry is
// examined on an empty stack. A call that pops n entries examines n + 1 (or
// n if it empties the stack); a return examines entries down to the match.
// One item is in flight at a time; the next is taken once the previous
// result sits in the output register.
// Reset clears the depth, the mode register and the output valid; memory
// contents are not cleared since entries at or above the depth are never read.
// When the receiver stalls, the result waits in the output register; a second
// finished result waits internally until the output register frees up.
module shadow_call_stack_tracker #(
   parameter int STACK_DEPTH = scst_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scst_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import scst_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [AW-1:0] scan_idx_ff, scan_idx_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          match_on_slot_ff, match_on_slot_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic          accept;
   logic          out_free;
   logic [31:0]   key;

   scst_stack_ram #(
      .STACK_DEPTH(STACK_DEPTH),
      .AW         (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign key       = match_on_slot_ff ? req_ff.slot_value : req_ff.instr_pointer;

   // mode register
   assign match_on_slot_in = csr_wr_en ? csr_wr_data : match_on_slot_ff;

   // sequencer: walk entries from the top, one read per cycle
   always_comb begin
      logic          call_end;
      logic [DW-1:0] keep;

      call_end     = 1'b0;
      keep         = depth_ff;
      state_in     = state_ff;
      req_in       = req_ff;
      depth_in     = depth_ff;
      scan_idx_in  = scan_idx_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '{saved_pointer: req_ff.stack_pointer, saved_slot: req_ff.slot_value};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (depth_ff == '0) begin
                  // empty stack: push at the bottom, or nothing to return to
                  if (req_data.mode == MODE_CALL) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = '{saved_pointer: req_data.stack_pointer,
                                  saved_slot: req_data.slot_value};
                     depth_in = DW'(1);
                     res_in   = '{status: ST_PUSHED, removed_count: '0,
                                  new_depth: 7'd1};
                  end else begin
                     res_in   = '{status: ST_NOT_FOUND, removed_count: '0,
                                  new_depth: '0};
                  end
                  state_in = S_DONE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = AW'(depth_ff - DW'(1));
                  scan_idx_in = AW'(depth_ff - DW'(1));
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (req_ff.mode == MODE_CALL) begin
               if (req_ff.stack_pointer >= rd_data.saved_pointer) begin
                  // this entry pops
                  if (scan_idx_ff == '0) begin
                     call_end = 1'b1;
                     keep     = '0;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = scan_idx_ff - AW'(1);
                     scan_idx_in = scan_idx_ff - AW'(1);
                  end
               end else begin
                  call_end = 1'b1;
                  keep     = DW'(scan_idx_ff) + DW'(1);
               end
            end else begin
               if (rd_data.saved_slot == key) begin
                  if (match_on_slot_ff ? (req_ff.stack_pointer > rd_data.saved_pointer)
                                       : (req_ff.stack_pointer <= rd_data.saved_pointer))
                  begin
                     res_in = '{status: ST_BAD_SP, removed_count: '0,
                                new_depth: 7'(depth_ff)};
                  end else begin
                     depth_in = DW'(scan_idx_ff);
                     res_in   = '{status: ST_MATCHED,
                                  removed_count: 7'(depth_ff - DW'(scan_idx_ff)),
                                  new_depth: 7'(scan_idx_ff)};
                  end
                  state_in = S_DONE;
               end else if (scan_idx_ff == '0) begin
                  res_in   = '{status: ST_NOT_FOUND, removed_count: '0,
                               new_depth: 7'(depth_ff)};
                  state_in = S_DONE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = scan_idx_ff - AW'(1);
                  scan_idx_in = scan_idx_ff - AW'(1);
               end
            end

            // end of the pop walk: push unless still full
            if (call_end) begin
               if (keep >= DW'(STACK_DEPTH)) begin
                  depth_in = keep;
                  res_in   = '{status: ST_FULL, removed_count: 7'(depth_ff - keep),
                               new_depth: 7'(keep)};
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(keep);
                  depth_in = keep + DW'(1);
                  res_in   = '{status: ST_PUSHED, removed_count: 7'(depth_ff - keep),
                               new_depth: 7'(keep + DW'(1))};
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         depth_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         match_on_slot_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         depth_ff         <= depth_in;
         rsp_valid_ff     <= rsp_valid_in;
         match_on_slot_ff <= match_on_slot_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // depth never exceeds the memory
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   // the walk only reads entries below the depth
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (DW'(scan_idx_ff) < depth_ff))
      else $error("scan index at or above depth");

   // a push leaves a non-empty stack
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status == ST_PUSHED) |-> (depth_ff != '0))
      else $error("push left an empty stack");

   // a memory write happens only as a call completes
   a_write_on_call: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (state_ff == S_DONE && req_ff.mode == MODE_CALL))
      else $error("memory write outside a call");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   import scst_pkg::*;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block ports
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // items waiting to be offered and results still owed by the block
   req_type pending_events[$];
   rsp_type predicted_results[$];

   // shadow of the tracker state kept by the bench
   logic [31:0] frame_sp[STACK_DEPTH_DEFAULT];
   logic [31:0] frame_slot[STACK_DEPTH_DEFAULT];
   int          frame_count = 0;
   bit          slot_mode = 1'b0;

   // stack picture used only to shape the random items
   logic [31:0] plan_sp[$];
   logic [31:0] plan_ret[$];

   // run bookkeeping
   int error_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int deepest_seen = 0;
   int status_hits[5] = '{default: 0};
   bit quiet_stretch = 1'b0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   shadow_call_stack_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // expected result of one event, advancing the shadow stack
   function automatic rsp_type track_event(req_type ev);
      rsp_type     res;
      logic [31:0] key;
      int          pos;
      int          removed;
      bit          bad;
      res = '0;
      removed = 0;
      if (ev.mode == MODE_CALL) begin
         // unwind frames at or below the new pointer, then push
         while (frame_count > 0 && ev.stack_pointer >= frame_sp[frame_count - 1]) begin
            frame_count--;
            removed++;
         end
         if (frame_count >= STACK_DEPTH_DEFAULT) begin
            res.status = ST_FULL;
         end else begin
            frame_sp[frame_count] = ev.stack_pointer;
            frame_slot[frame_count] = ev.slot_value;
            frame_count++;
            res.status = ST_PUSHED;
         end
      end else begin
         // search from the top for the return key
         key = slot_mode ? ev.slot_value : ev.instr_pointer;
         pos = frame_count;
         while (pos > 0 && frame_slot[pos - 1] != key)
            pos--;
         if (pos == 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            bad = slot_mode ? (ev.stack_pointer > frame_sp[pos - 1])
                            : (ev.stack_pointer <= frame_sp[pos - 1]);
            if (bad) begin
               res.status = ST_BAD_SP;
            end else begin
               removed = frame_count - (pos - 1);
               frame_count = pos - 1;
               res.status = ST_MATCHED;
            end
         end
      end
      res.removed_count = 7'(removed);
      res.new_depth = 7'(frame_count);
      return res;
   endfunction

   function automatic req_type make_event(logic m, logic [31:0] sp, logic [31:0] slot,
                                          logic [31:0] ip);
      req_type ev;
      ev.mode = m;
      ev.stack_pointer = sp;
      ev.slot_value = slot;
      ev.instr_pointer = ip;
      return ev;
   endfunction

   // append one item to the send list
   function automatic void queue_event(req_type ev);
      pending_events.insert(pending_events.size(), ev);
   endfunction

   // driver: offer pending items, predict each one at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.insert(predicted_results.size(), track_event(req_data));
            accepted_count++;
            if (frame_count > deepest_seen)
               deepest_seen = frame_count;
         end
         if (!req_valid || req_ready) begin
            if (pending_events.size() > 0 && (quiet_stretch || $urandom_range(99) >= 6)) begin
               req_data <= pending_events.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result item with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (predicted_results.size() == 0) begin
               $error("result with nothing expected: status %0d removed %0d depth %0d",
                      rsp_data.status, rsp_data.removed_count, rsp_data.new_depth);
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.removed_count !== want.removed_count) begin
                  $error("removed_count mismatch: expected %0d, actual %0d",
                         want.removed_count, rsp_data.removed_count);
                  error_count++;
               end
               if (rsp_data.new_depth !== want.new_depth) begin
                  $error("new_depth mismatch: expected %0d, actual %0d",
                         want.new_depth, rsp_data.new_depth);
                  error_count++;
               end
            end
            if (rsp_data.status <= ST_BAD_SP)
               status_hits[rsp_data.status]++;
         end
         // one long hold-off so the block backs up into its input
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && result_count >= 60) begin
            hold_left <= 300;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch || $urandom_range(99) >= 6;
         end
      end
   end

   // mode register write, only called while the block is idle
   task automatic write_mode(bit m);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      slot_mode = m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sender pause until every owed result is back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_events.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   // random call/return traffic, mostly shaped like real nested calls
   task automatic queue_random(int count, int call_pct, int unwind_pct);
      int          n;
      int          k;
      bit          bad;
      logic [31:0] sp;
      logic [31:0] key;
      logic [31:0] base;
      req_type     ev;
      plan_sp.delete();
      plan_ret.delete();
      for (int i = 0; i < frame_count; i++) begin
         plan_sp.insert(plan_sp.size(), frame_sp[i]);
         plan_ret.insert(plan_ret.size(), frame_slot[i]);
      end
      for (int i = 0; i < count; i++) begin
         n = plan_sp.size();
         k = -1;
         if ($urandom_range(99) < 8) begin
            // noise
            ev = make_event(1'($urandom_range(1)), $urandom, $urandom, $urandom);
         end else if ($urandom_range(99) < call_pct) begin
            if (n == 0 || plan_sp[n - 1] < 32'h400)
               sp = $urandom;
            else if ($urandom_range(99) < unwind_pct)
               sp = plan_sp[$urandom_range(n - 1)];
            else
               sp = plan_sp[n - 1] - $urandom_range(4, 256);
            key = (n > 0 && $urandom_range(99) < 10) ? plan_ret[$urandom_range(n - 1)]
                                                      : $urandom;
            ev = make_event(MODE_CALL, sp, key, $urandom);
         end else if (n == 0 || $urandom_range(99) < 10) begin
            ev = make_event(MODE_RETURN, $urandom, $urandom, $urandom);
         end else begin
            k = ($urandom_range(99) < 75) ? n - 1 : $urandom_range(n - 1);
            key = plan_ret[k];
            base = plan_sp[k];
            bad = $urandom_range(99) < 10;
            if (slot_mode) begin
               sp = bad ? base + $urandom_range(1, 64) : base;
               ev = make_event(MODE_RETURN, sp, key, $urandom);
            end else begin
               sp = bad ? base - $urandom_range(0, 16) : base + $urandom_range(1, 16);
               ev = make_event(MODE_RETURN, sp, $urandom, key);
            end
            if (bad)
               k = -1;
         end
         // rough update of the planning picture
         if (ev.mode == MODE_CALL) begin
            while (plan_sp.size() > 0 && ev.stack_pointer >= plan_sp[plan_sp.size() - 1]) begin
               plan_sp.delete(plan_sp.size() - 1);
               plan_ret.delete(plan_ret.size() - 1);
            end
            if (plan_sp.size() < STACK_DEPTH_DEFAULT) begin
               plan_sp.insert(plan_sp.size(), ev.stack_pointer);
               plan_ret.insert(plan_ret.size(), ev.slot_value);
            end
         end else if (k >= 0) begin
            while (plan_sp.size() > k) begin
               plan_sp.delete(plan_sp.size() - 1);
               plan_ret.delete(plan_ret.size() - 1);
            end
         end
         queue_event(ev);
      end
   endtask

   // stimulus and end of run
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, matching on instruction pointer
      write_mode(1'b0);
      queue_event(make_event(MODE_RETURN, 32'h0, 32'h0, 32'h0));
      queue_event(make_event(MODE_CALL, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
      queue_event(make_event(MODE_CALL, 32'h0, 32'hFFFF_FFFF, 32'h0));
      queue_event(make_event(MODE_CALL, 32'h1000, 32'hA0, 32'h1));
      queue_event(make_event(MODE_CALL, 32'h800, 32'hB0, 32'h2));
      queue_event(make_event(MODE_CALL, 32'h400, 32'hC0, 32'h3));
      queue_event(make_event(MODE_RETURN, 32'h400, 32'h5, 32'hC0));
      queue_event(make_event(MODE_RETURN, 32'h404, 32'h5, 32'hC0));
      queue_event(make_event(MODE_RETURN, 32'h2000, 32'hC0, 32'h1234_5678));
      queue_event(make_event(MODE_RETURN, 32'h2000, 32'h0, 32'hA0));
      queue_event(make_event(MODE_RETURN, 32'hFFFF_FFFF, 32'h1, 32'h0));
      queue_event(make_event(MODE_CALL, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0));
      wait_drained();

      // directed, matching on slot value, with a duplicate key on the stack
      write_mode(1'b1);
      queue_event(make_event(MODE_CALL, 32'h100, 32'h55, 32'h0));
      queue_event(make_event(MODE_CALL, 32'h80, 32'hAA, 32'h0));
      queue_event(make_event(MODE_RETURN, 32'h81, 32'hAA, 32'hAA));
      queue_event(make_event(MODE_RETURN, 32'h80, 32'hAA, 32'h0));
      queue_event(make_event(MODE_RETURN, 32'h80, 32'h77, 32'h55));
      queue_event(make_event(MODE_CALL, 32'h70, 32'h55, 32'h0));
      queue_event(make_event(MODE_RETURN, 32'h70, 32'h55, 32'h0));
      queue_event(make_event(MODE_RETURN, 32'h0, 32'hDEAD_BEEF, 32'h0));
      queue_event(make_event(MODE_RETURN, 32'h0, 32'h0, 32'h0));
      queue_event(make_event(MODE_CALL, 32'h0, 32'h0, 32'hFFFF_FFFF));
      wait_drained();

      // random phases, alternating the match mode, two of them deep enough to fill
      write_mode(1'b0);
      queue_random(70, 55, 15);
      wait_drained();
      write_mode(1'b1);
      queue_random(120, 95, 2);
      wait_drained();
      quiet_stretch = 1'b1;
      write_mode(1'b0);
      queue_random(80, 50, 15);
      wait_drained();
      quiet_stretch = 1'b0;
      write_mode(1'b1);
      queue_random(80, 50, 15);
      wait_drained();
      write_mode(1'b0);
      queue_random(60, 90, 2);
      wait_drained();

      repeat (80) @(posedge clock);
      $display("covered %0d events in both match modes, deepest stack %0d of %0d",
               accepted_count, deepest_seen, STACK_DEPTH_DEFAULT);
      $display("statuses: pushed %0d, full %0d, matched %0d, not found %0d, bad pointer %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4]);
      if (error_count == 0 && predicted_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
